/* design/owbm_pkg.sv */
// ----------------------------------------------------------------------------
// owbm_pkg: shared types and constants for the one-wire bus master
// Beat payloads, timing register set, register indexes and command codes.
// ----------------------------------------------------------------------------
package owbm_pkg;

  // Command codes carried in the mode field
  localparam logic [1:0] MODE_RESET = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // Timing register indexes (byte address is 4 * index)
  localparam logic [2:0] REG_RESET_LOW     = 3'd0;
  localparam logic [2:0] REG_PRESENCE_SMPL = 3'd1;
  localparam logic [2:0] REG_LONG_LOW      = 3'd2;
  localparam logic [2:0] REG_SHORT_LOW     = 3'd3;
  localparam logic [2:0] REG_SHORT_REL     = 3'd4;
  localparam logic [2:0] REG_LONG_REL      = 3'd5;
  localparam logic [2:0] REG_READ_SMPL     = 3'd6;
  localparam logic [2:0] REG_READ_REC      = 3'd7;

  localparam int unsigned ADDR_W = 5;

  // Input beat
  typedef struct packed {
    logic       tick;
    logic       start_req;
    logic [1:0] mode;
    logic [7:0] tx_byte;
    logic       line_level;
  } in_item_t;

  // Result beat
  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] rx_byte;
  } out_item_t;

  // Timing registers as seen by the sequencer
  typedef struct packed {
    logic [8:0] reset_low_time;
    logic [7:0] presence_sample_time;
    logic [7:0] long_low_time;
    logic [7:0] short_low_time;
    logic [7:0] short_release_time;
    logic [7:0] long_release_time;
    logic [7:0] read_sample_time;
    logic [7:0] read_recovery_time;
  } timing_cfg_t;

  // Bus sequencer phases, one-hot
  typedef enum logic [7:0] {
    PH_IDLE     = 8'b0000_0001,
    PH_RST_LOW  = 8'b0000_0010,
    PH_RST_WAIT = 8'b0000_0100,
    PH_WR_LOW   = 8'b0000_1000,
    PH_WR_REL   = 8'b0001_0000,
    PH_RD_LOW   = 8'b0010_0000,
    PH_RD_WAIT  = 8'b0100_0000,
    PH_RD_REC   = 8'b1000_0000
  } phase_t;

endpackage

/* design/one_wire_bus_master_top.sv */
// ----------------------------------------------------------------------------
// one_wire_bus_master_top: single-wire open-drain bus master
// Usage:
//   The input channel carries one beat per bus time step: the microsecond
//   tick, a command request (bus reset, write byte, read byte), the byte to
//   send and the sampled line level. A request is taken only while idle.
//   Every input beat yields exactly one result beat: drive level, busy,
//   done, presence of the last reset and the byte of the last read.
//   The result of an accepted beat is registered and valid in the cycle
//   after it is accepted. Throughput is one beat per cycle while the
//   receiver does not stall, set by the phase sequencer and its output register.
//   When the receiver stalls, the result is held in the output register
//   and in_stall is raised until it has been taken; a new beat is accepted
//   in the same cycle the held result leaves.
//   The user writes timing registers through the APB-style port only while idle;
//   the block does not enforce this. Reset returns the sequencer to idle, clears
//   presence and the received byte and loads the standard bus timings.
// ----------------------------------------------------------------------------
module one_wire_bus_master_top
  import owbm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  timing_cfg_t timing;

  phase_t     phase_r, phase_nxt;
  logic [8:0] timer_r, timer_nxt;
  logic [2:0] bit_r, bit_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic       presence_r, presence_nxt;
  logic [7:0] rx_r, rx_nxt;
  logic       done;

  logic       out_valid_r;
  out_item_t  out_data_r, out_data_nxt;

  logic       accept;
  logic [8:0] phase_len;
  logic [9:0] timer_inc;

  owbm_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .timing  (timing)
  );

  // Handshake: hold input while a result waits and is stalled
  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Length of the current phase in ticks
  always_comb begin
    unique case (phase_r)
      PH_RST_LOW:  phase_len = timing.reset_low_time;
      PH_RST_WAIT: phase_len = {1'b0, timing.presence_sample_time};
      PH_WR_LOW:   phase_len = {1'b0, shift_r[0] ? timing.short_low_time
                                                 : timing.long_low_time};
      PH_WR_REL:   phase_len = {1'b0, shift_r[0] ? timing.long_release_time
                                                 : timing.short_release_time};
      PH_RD_LOW:   phase_len = {1'b0, timing.short_low_time};
      PH_RD_WAIT:  phase_len = {1'b0, timing.read_sample_time};
      PH_RD_REC:   phase_len = {1'b0, timing.read_recovery_time};
      default:     phase_len = 9'd1;
    endcase
  end

  assign timer_inc = {1'b0, timer_r} + 10'd1;

  // Phase sequencer, one step per accepted beat
  always_comb begin
    phase_nxt    = phase_r;
    timer_nxt    = timer_r;
    bit_nxt      = bit_r;
    shift_nxt    = shift_r;
    presence_nxt = presence_r;
    rx_nxt       = rx_r;
    done         = 1'b0;
    if (phase_r == PH_IDLE) begin
      if (in_data.start_req) begin
        timer_nxt = 9'd0;
        bit_nxt   = 3'd0;
        priority if (in_data.mode == MODE_RESET) begin
          phase_nxt = PH_RST_LOW;
        end else if (in_data.mode == MODE_WRITE) begin
          phase_nxt = PH_WR_LOW;
          shift_nxt = in_data.tx_byte;
        end else if (in_data.mode == MODE_READ) begin
          phase_nxt = PH_RD_LOW;
          shift_nxt = 8'd0;
        end else begin
          // unused command code: stay idle, nothing changes
          timer_nxt = timer_r;
          bit_nxt   = bit_r;
        end
      end
    end else if (in_data.tick) begin
      if (timer_inc >= {1'b0, phase_len}) begin
        timer_nxt = 9'd0;
        unique case (phase_r)
          PH_RST_LOW: begin
            phase_nxt = PH_RST_WAIT;
          end
          PH_RST_WAIT: begin
            presence_nxt = ~in_data.line_level;
            phase_nxt    = PH_IDLE;
            done         = 1'b1;
          end
          PH_WR_LOW: begin
            phase_nxt = PH_WR_REL;
          end
          PH_WR_REL: begin
            shift_nxt = {1'b0, shift_r[7:1]};
            if (bit_r == 3'd7) begin
              bit_nxt   = 3'd0;
              phase_nxt = PH_IDLE;
              done      = 1'b1;
            end else begin
              bit_nxt   = bit_r + 3'd1;
              phase_nxt = PH_WR_LOW;
            end
          end
          PH_RD_LOW: begin
            phase_nxt = PH_RD_WAIT;
          end
          PH_RD_WAIT: begin
            // LSB-first: new bit enters at the top
            shift_nxt = {in_data.line_level, shift_r[7:1]};
            phase_nxt = PH_RD_REC;
          end
          PH_RD_REC: begin
            if (bit_r == 3'd7) begin
              bit_nxt   = 3'd0;
              rx_nxt    = shift_r;
              phase_nxt = PH_IDLE;
              done      = 1'b1;
            end else begin
              bit_nxt   = bit_r + 3'd1;
              phase_nxt = PH_RD_LOW;
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end else begin
        timer_nxt = timer_inc[8:0];
      end
    end
  end

  // Result beat built from the post-step state
  always_comb begin
    out_data_nxt.drive_low = (phase_nxt == PH_RST_LOW) || (phase_nxt == PH_WR_LOW) ||
                             (phase_nxt == PH_RD_LOW);
    out_data_nxt.busy_res  = (phase_nxt != PH_IDLE);
    out_data_nxt.done_res  = done;
    out_data_nxt.presence  = presence_nxt;
    out_data_nxt.rx_byte   = rx_nxt;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      timer_r    <= 9'd0;
      bit_r      <= 3'd0;
      shift_r    <= 8'd0;
      presence_r <= 1'b0;
      rx_r       <= 8'd0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      timer_r    <= timer_nxt;
      bit_r      <= bit_nxt;
      shift_r    <= shift_nxt;
      presence_r <= presence_nxt;
      rx_r       <= rx_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

/* design/owbm_regs.sv */
// ----------------------------------------------------------------------------
// owbm_regs: timing register file
// APB-style write and read access to the eight slot timing registers.
// ----------------------------------------------------------------------------
module owbm_regs
  import owbm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output timing_cfg_t       timing
);

  timing_cfg_t cfg_r;
  logic        wr_en;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign timing  = cfg_r;

  // Register writes, reset to the standard bus timings
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low_time       <= 9'd480;
      cfg_r.presence_sample_time <= 8'd60;
      cfg_r.long_low_time        <= 8'd60;
      cfg_r.short_low_time       <= 8'd5;
      cfg_r.short_release_time   <= 8'd15;
      cfg_r.long_release_time    <= 8'd60;
      cfg_r.read_sample_time     <= 8'd10;
      cfg_r.read_recovery_time   <= 8'd30;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_RESET_LOW:     cfg_r.reset_low_time       <= pwdata[8:0];
        REG_PRESENCE_SMPL: cfg_r.presence_sample_time <= pwdata[7:0];
        REG_LONG_LOW:      cfg_r.long_low_time        <= pwdata[7:0];
        REG_SHORT_LOW:     cfg_r.short_low_time       <= pwdata[7:0];
        REG_SHORT_REL:     cfg_r.short_release_time   <= pwdata[7:0];
        REG_LONG_REL:      cfg_r.long_release_time    <= pwdata[7:0];
        REG_READ_SMPL:     cfg_r.read_sample_time     <= pwdata[7:0];
        REG_READ_REC:      cfg_r.read_recovery_time   <= pwdata[7:0];
        default:           cfg_r.reset_low_time       <= cfg_r.reset_low_time;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_idx)
      REG_RESET_LOW:     prdata = {23'd0, cfg_r.reset_low_time};
      REG_PRESENCE_SMPL: prdata = {24'd0, cfg_r.presence_sample_time};
      REG_LONG_LOW:      prdata = {24'd0, cfg_r.long_low_time};
      REG_SHORT_LOW:     prdata = {24'd0, cfg_r.short_low_time};
      REG_SHORT_REL:     prdata = {24'd0, cfg_r.short_release_time};
      REG_LONG_REL:      prdata = {24'd0, cfg_r.long_release_time};
      REG_READ_SMPL:     prdata = {24'd0, cfg_r.read_sample_time};
      REG_READ_REC:      prdata = {24'd0, cfg_r.read_recovery_time};
      default:           prdata = 32'd0;
    endcase
  end

endmodule
